// ===== sv/hbp_pkg.sv =====
`default_nettype none

package hbp_pkg;

   // Predictor mode register codes; the unused code behaves as hybrid.
   typedef enum logic [1:0] {
      MODE_BIMODAL = 2'd0,
      MODE_GSHARE  = 2'd1,
      MODE_HYBRID  = 2'd2
   } mode_type;

   // Register byte addresses on the configuration port.
   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MODE_ADDR = 3'd0;

   // Three-bit direction counters.
   localparam logic [2:0] CTR_MAX   = 3'd7;
   localparam logic [2:0] CTR_INIT  = 3'd4;
   localparam logic [2:0] CTR_TAKEN = 3'd4;

   // Two-bit chooser counters.
   localparam logic [1:0] SEL_MAX    = 2'd3;
   localparam logic [1:0] SEL_INIT   = 2'd1;
   localparam logic [1:0] SEL_GSHARE = 2'd2;

   // Stream payload widths, padded to whole bytes.
   localparam int unsigned REQ_DATA_BITS = 40;
   localparam int unsigned RSP_DATA_BITS = 72;

   // Saturating step of a direction counter toward the outcome.
   function automatic logic [2:0] train_ctr(input logic [2:0] c, input logic t);
      logic [2:0] r;
      r = c;
      if (t) begin
         if (c != CTR_MAX) r = c + 3'd1;
      end else begin
         if (c != 3'd0) r = c - 3'd1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/hybrid_branch_predictor.sv =====
`default_nettype none

// Channel    Direction  Payload
// req_*      in         tdata: branch_address[31:0], taken[32], zero pad
// rsp_*      out        tdata: predicted_taken, mispredicted, prediction_total,
//                       mispredict_total; tuser: used_gshare
// csr_*      in/out     predictor_mode register at byte address 0
//
// One branch is taken every cycle while the result channel does not stall. A result
// passes the registered read of the counter tables into the output register, and
// can leave from there on the result channel.
// After reset a clearing pass writes every table entry, stepping through every index
// of the widest table; no branch is taken then.
// A stalled result holds the read stage, which in turn holds the input channel.
module hybrid_branch_predictor #(
   parameter int unsigned BIMODAL_INDEX_BITS = 10,
   parameter int unsigned GSHARE_INDEX_BITS  = 10,
   parameter int unsigned HISTORY_BITS       = 8,
   parameter int unsigned CHOOSER_INDEX_BITS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Branch input.
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // branch_address [31:0], taken [32], zeros [39:33]
   input  wire logic [hbp_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // Prediction result.
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // predicted_taken [0], mispredicted [1], prediction_total [33:2],
   // mispredict_total [65:34], zeros [71:66]
   output      logic [hbp_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // used_gshare [0]
   output      logic                                rsp_tuser,
   // Configuration port.
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [hbp_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [31:0]                         csr_pwdata,
   output      logic [31:0]                         csr_prdata,
   output      logic                                csr_pready
);
   import hbp_pkg::*;

   localparam int unsigned BI = BIMODAL_INDEX_BITS;
   localparam int unsigned GI = GSHARE_INDEX_BITS;
   localparam int unsigned CI = CHOOSER_INDEX_BITS;
   localparam int unsigned HB = HISTORY_BITS;
   localparam int unsigned MAX_BG = (BI > GI) ? BI : GI;
   localparam int unsigned CLR_BITS = (MAX_BG > CI) ? MAX_BG : CI;

   // Counter tables.
   logic [2:0] bim_mem [2**BI];
   logic [2:0] gsh_mem [2**GI];
   logic [1:0] cho_mem [2**CI];

   // Control and state registers.
   logic [1:0]          mode_ff;
   logic [HB-1:0]       hist_ff, hist_in;
   logic                clearing_ff;
   logic [CLR_BITS-1:0] clear_cnt_ff;
   logic [31:0]         pred_cnt_ff, pred_cnt_in;
   logic [31:0]         miss_cnt_ff, miss_cnt_in;

   // Read stage registers.
   logic          s1_valid_ff;
   logic          s1_taken_ff;
   logic [BI-1:0] s1_bidx_ff;
   logic [GI-1:0] s1_gidx_ff;
   logic [CI-1:0] s1_cidx_ff;
   logic [2:0]    bim_rd_ff, gsh_rd_ff;
   logic [1:0]    cho_rd_ff;

   // Bypass of the write made at the same edge as the read.
   logic          bim_fwd_vld_ff, gsh_fwd_vld_ff, cho_fwd_vld_ff;
   logic [BI-1:0] bim_fwd_idx_ff;
   logic [GI-1:0] gsh_fwd_idx_ff;
   logic [CI-1:0] cho_fwd_idx_ff;
   logic [2:0]    bim_fwd_dat_ff, gsh_fwd_dat_ff;
   logic [1:0]    cho_fwd_dat_ff;

   // Output register.
   logic        out_valid_ff;
   logic        out_pred_ff, out_miss_ff, out_useg_ff;
   logic [31:0] out_pred_cnt_ff, out_miss_cnt_ff;

   // Combinational signals.
   logic          accept, s1_advance;
   logic [29:0]   word_addr, hist_ext;
   logic          in_taken;
   logic [BI-1:0] in_bidx;
   logic [GI-1:0] in_gidx;
   logic [CI-1:0] in_cidx;
   logic [2:0]    bim_cur, gsh_cur, bim_new, gsh_new;
   logic [1:0]    cho_cur, cho_new;
   logic          bpred, gpred, use_g, pred, miss, is_hybrid;
   logic          bim_we, gsh_we, cho_we;
   logic          csr_wr;

   // Handshakes.
   assign s1_advance = ~out_valid_ff | rsp_tready;
   assign req_tready = ~clearing_ff & (~s1_valid_ff | s1_advance);
   assign accept     = req_tvalid & req_tready;
   assign is_hybrid  = (mode_ff != MODE_BIMODAL) && (mode_ff != MODE_GSHARE);

   // Table indexes from the incoming branch and the current history.
   assign word_addr = req_tdata[31:2];
   assign in_taken  = req_tdata[32];
   assign hist_ext  = 30'(hist_ff);
   assign in_bidx   = word_addr[BI-1:0];
   assign in_cidx   = word_addr[CI-1:0];
   assign in_gidx   = word_addr[GI-1:0] ^ hist_ext[GI-1:0];

   // The history depends only on the outcome, so it moves at the transfer, except in bimodal mode.
   always_comb begin
      hist_in = hist_ff >> 1;
      hist_in[HB-1] = in_taken;
   end

   // Table entries for the branch in the read stage, with bypass.
   always_comb begin
      bim_cur = (bim_fwd_vld_ff && bim_fwd_idx_ff == s1_bidx_ff) ? bim_fwd_dat_ff : bim_rd_ff;
      gsh_cur = (gsh_fwd_vld_ff && gsh_fwd_idx_ff == s1_gidx_ff) ? gsh_fwd_dat_ff : gsh_rd_ff;
      cho_cur = (cho_fwd_vld_ff && cho_fwd_idx_ff == s1_cidx_ff) ? cho_fwd_dat_ff : cho_rd_ff;
   end

   // Prediction, training and totals.
   always_comb begin
      bpred = (bim_cur >= CTR_TAKEN);
      gpred = (gsh_cur >= CTR_TAKEN);
      if (mode_ff == MODE_BIMODAL) begin
         use_g = 1'b0;
      end else if (mode_ff == MODE_GSHARE) begin
         use_g = 1'b1;
      end else begin
         use_g = (cho_cur >= SEL_GSHARE);
      end
      pred = use_g ? gpred : bpred;
      miss = (pred != s1_taken_ff);

      bim_new = train_ctr(bim_cur, s1_taken_ff);
      gsh_new = train_ctr(gsh_cur, s1_taken_ff);

      // The chooser leans toward whichever predictor alone was right.
      cho_new = cho_cur;
      if (gpred == s1_taken_ff && bpred != s1_taken_ff) begin
         if (cho_cur != SEL_MAX) cho_new = cho_cur + 2'd1;
      end else if (gpred != s1_taken_ff && bpred == s1_taken_ff) begin
         if (cho_cur != 2'd0) cho_new = cho_cur - 2'd1;
      end

      bim_we = s1_valid_ff & s1_advance & ~use_g;
      gsh_we = s1_valid_ff & s1_advance & use_g;
      cho_we = s1_valid_ff & s1_advance & is_hybrid;

      pred_cnt_in = (pred_cnt_ff == 32'hFFFF_FFFF) ? pred_cnt_ff : pred_cnt_ff + 32'd1;
      miss_cnt_in = (miss && miss_cnt_ff != 32'hFFFF_FFFF) ? miss_cnt_ff + 32'd1 : miss_cnt_ff;
   end

   // Table writes: the clearing pass after reset, then training.
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         bim_mem[clear_cnt_ff[BI-1:0]] <= CTR_INIT;
         gsh_mem[clear_cnt_ff[GI-1:0]] <= CTR_INIT;
         cho_mem[clear_cnt_ff[CI-1:0]] <= SEL_INIT;
      end else begin
         if (bim_we) bim_mem[s1_bidx_ff] <= bim_new;
         if (gsh_we) gsh_mem[s1_gidx_ff] <= gsh_new;
         if (cho_we) cho_mem[s1_cidx_ff] <= cho_new;
      end
   end

   // Table reads at the transfer.
   always_ff @(posedge clock) begin
      if (accept) begin
         bim_rd_ff <= bim_mem[in_bidx];
         gsh_rd_ff <= gsh_mem[in_gidx];
         cho_rd_ff <= cho_mem[in_cidx];
      end
   end

   // Read stage payload and bypass data.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_taken_ff    <= in_taken;
         s1_bidx_ff     <= in_bidx;
         s1_gidx_ff     <= in_gidx;
         s1_cidx_ff     <= in_cidx;
         bim_fwd_idx_ff <= s1_bidx_ff;
         gsh_fwd_idx_ff <= s1_gidx_ff;
         cho_fwd_idx_ff <= s1_cidx_ff;
         bim_fwd_dat_ff <= bim_new;
         gsh_fwd_dat_ff <= gsh_new;
         cho_fwd_dat_ff <= cho_new;
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_advance) begin
         out_pred_ff     <= pred;
         out_miss_ff     <= miss;
         out_useg_ff     <= use_g;
         out_pred_cnt_ff <= pred_cnt_in;
         out_miss_cnt_ff <= miss_cnt_in;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_HYBRID;
         hist_ff        <= '0;
         clearing_ff    <= 1'b1;
         clear_cnt_ff   <= '0;
         pred_cnt_ff    <= '0;
         miss_cnt_ff    <= '0;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         bim_fwd_vld_ff <= 1'b0;
         gsh_fwd_vld_ff <= 1'b0;
         cho_fwd_vld_ff <= 1'b0;
      end else begin
         if (csr_wr) mode_ff <= csr_pwdata[1:0];

         if (clearing_ff) begin
            clear_cnt_ff <= clear_cnt_ff + CLR_BITS'(1);
            if (clear_cnt_ff == '1) clearing_ff <= 1'b0;
         end

         if (accept) begin
            if (mode_ff != MODE_BIMODAL) hist_ff <= hist_in;
            bim_fwd_vld_ff <= bim_we;
            gsh_fwd_vld_ff <= gsh_we;
            cho_fwd_vld_ff <= cho_we;
            s1_valid_ff    <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end

         if (s1_valid_ff && s1_advance) begin
            pred_cnt_ff  <= pred_cnt_in;
            miss_cnt_ff  <= miss_cnt_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Result channel.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_useg_ff;
   assign rsp_tdata  = {6'd0, out_miss_cnt_ff, out_pred_cnt_ff, out_miss_ff, out_pred_ff};

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & (csr_paddr == CSR_MODE_ADDR);
   assign csr_prdata = (csr_paddr == CSR_MODE_ADDR) ? {30'd0, mode_ff} : 32'd0;

   // No branch is taken while the tables are being cleared.
   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req_tready)
      else $error("branch transfer during clearing pass");

   // A branch held in the read stage stays there while the output stalls.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_bidx_ff) && $stable(s1_gidx_ff)))
      else $error("read stage lost a stalled branch");

   // Mispredictions never outnumber branches.
   a_totals: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_miss_cnt_ff <= out_pred_cnt_ff))
      else $error("mispredict total exceeds branch total");

   // A misprediction always has a nonzero total behind it.
   a_miss_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_miss_ff) |-> (out_miss_cnt_ff != 32'd0))
      else $error("mispredicted result with zero total");

endmodule

`default_nettype wire
